[src/assert_macros.svh]
// Assertion helpers shared by the timer pool modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Property must hold at every rising edge out of reset.
`define ASSERT_AT(label, clk, rstn, prop) \
    label: assert property (@(posedge clk) disable iff (!rstn) prop) \
        else $error("assertion failed: %m");

// Expression must never be true out of reset.
`define ASSERT_NEVER(label, clk, rstn, expr) \
    label: assert property (@(posedge clk) disable iff (!rstn) !(expr)) \
        else $error("forbidden condition seen: %m");

`else

`define ASSERT_AT(label, clk, rstn, prop)
`define ASSERT_NEVER(label, clk, rstn, expr)

`endif

`endif

[src/ttp_pkg.sv]
`default_nettype none

package ttp_pkg;

    // Opcodes
    localparam logic [2:0] OP_OPEN  = 3'd0;
    localparam logic [2:0] OP_CLOSE = 3'd1;
    localparam logic [2:0] OP_START = 3'd2;
    localparam logic [2:0] OP_STOP  = 3'd3;
    localparam logic [2:0] OP_QUERY = 3'd4;
    localparam logic [2:0] OP_TICK  = 3'd5;

    // Result status codes
    localparam logic [2:0] ST_OK      = 3'd0;
    localparam logic [2:0] ST_ERROR   = 3'd1;
    localparam logic [2:0] ST_EXPIRED = 3'd2;
    localparam logic [2:0] ST_RUNNING = 3'd3;
    localparam logic [2:0] ST_STOPPED = 3'd4;

    localparam int RATE_W = 17;
    localparam logic [RATE_W-1:0] RATE_RESET = 17'd1000;

    // Millisecond conversion: shift-add multiply, then radix-16 restoring divide by 1000
    localparam int REM_W     = 10;
    localparam logic [REM_W-1:0] DIVISOR = 10'd1000;
    localparam int MUL_STEPS = RATE_W;
    localparam int DIV_BITS  = 4;
    localparam int DIV_STEPS = 13;
    localparam int ACC_W     = DIV_BITS * DIV_STEPS;
    localparam int CNT_W     = 5;

    typedef struct packed {
        logic [2:0]  opcode;
        logic [7:0]  slot_handle;
        logic [31:0] duration_ms;
    } ttp_in_t;

    typedef struct packed {
        logic [2:0] status;
        logic [7:0] granted_slot;
    } ttp_out_t;

    typedef struct packed {
        logic       load;
        logic       scan_init;
        logic       scan_step;
        logic       claim;
        logic       close;
        logic       stop;
        logic       tick;
        logic       mul_init;
        logic       mul_step;
        logic       div_step;
        logic       store;
        logic       res_set;
        logic [2:0] res_status;
        logic       res_grant;
        logic       out_load;
    } ttp_cmd_t;

    typedef struct packed {
        logic [2:0] op;
        logic       handle_ok;
        logic       in_use;
        logic       running;
        logic       scan_free;
        logic       scan_last;
        logic       cnt_zero;
        logic       expired;
        logic       out_busy;
    } ttp_sts_t;

endpackage

`default_nettype wire

[src/ttp_ctrl.sv]
`default_nettype none
`include "assert_macros.svh"

module ttp_ctrl
    import ttp_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     in_valid,
    output logic          in_ready,
    input  wire ttp_sts_t sts,
    output ttp_cmd_t      cmd
);

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_DECODE = 3'd1;
    localparam logic [2:0] S_SCAN   = 3'd2;
    localparam logic [2:0] S_QUERY  = 3'd3;
    localparam logic [2:0] S_MUL    = 3'd4;
    localparam logic [2:0] S_DIV    = 3'd5;
    localparam logic [2:0] S_STORE  = 3'd6;
    localparam logic [2:0] S_RESP   = 3'd7;

    logic [2:0] state_reg;
    logic [2:0] state_next;
    logic       slot_ok;

    assign in_ready = (state_reg == S_IDLE);
    assign slot_ok  = sts.handle_ok && sts.in_use;

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_DECODE;
                end
            end
            S_DECODE:
            begin
                cmd.res_set    = 1'b1;
                cmd.res_status = ST_ERROR;
                state_next     = S_RESP;
                unique case (sts.op)
                    OP_OPEN:
                    begin
                        cmd.res_set   = 1'b0;
                        cmd.scan_init = 1'b1;
                        state_next    = S_SCAN;
                    end
                    OP_CLOSE:
                    begin
                        if (sts.handle_ok)
                        begin
                            cmd.close      = 1'b1;
                            cmd.res_status = ST_OK;
                        end
                    end
                    OP_START:
                    begin
                        if (slot_ok)
                        begin
                            cmd.res_set  = 1'b0;
                            cmd.mul_init = 1'b1;
                            state_next   = S_MUL;
                        end
                    end
                    OP_STOP:
                    begin
                        if (slot_ok)
                        begin
                            cmd.stop       = 1'b1;
                            cmd.res_status = ST_OK;
                        end
                    end
                    OP_QUERY:
                    begin
                        if (slot_ok && !sts.running)
                        begin
                            cmd.res_status = ST_STOPPED;
                        end
                        else if (slot_ok)
                        begin
                            // go to S_QUERY so that the registered expiry read is valid
                            cmd.res_set = 1'b0;
                            state_next  = S_QUERY;
                        end
                    end
                    OP_TICK:
                    begin
                        cmd.tick       = 1'b1;
                        cmd.res_status = ST_OK;
                    end
                    default:
                    begin
                        cmd.res_status = ST_ERROR;
                    end
                endcase
            end
            S_SCAN:
            begin
                if (sts.scan_free)
                begin
                    cmd.claim      = 1'b1;
                    cmd.res_set    = 1'b1;
                    cmd.res_status = ST_OK;
                    cmd.res_grant  = 1'b1;
                    state_next     = S_RESP;
                end
                else if (sts.scan_last)
                begin
                    cmd.res_set    = 1'b1;
                    cmd.res_status = ST_ERROR;
                    state_next     = S_RESP;
                end
                else
                begin
                    cmd.scan_step = 1'b1;
                end
            end
            S_QUERY:
            begin
                cmd.res_set    = 1'b1;
                cmd.res_status = sts.expired ? ST_EXPIRED : ST_RUNNING;
                state_next     = S_RESP;
            end
            S_MUL:
            begin
                cmd.mul_step = 1'b1;
                if (sts.cnt_zero)
                begin
                    state_next = S_DIV;
                end
            end
            S_DIV:
            begin
                cmd.div_step = 1'b1;
                if (sts.cnt_zero)
                begin
                    state_next = S_STORE;
                end
            end
            S_STORE:
            begin
                cmd.store      = 1'b1;
                cmd.res_set    = 1'b1;
                cmd.res_status = ST_OK;
                state_next     = S_RESP;
            end
            S_RESP:
            begin
                // hold until the output register is free
                if (!sts.out_busy)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    `ASSERT_AT(a_arith_only_start, clk, rst_n,
        (state_reg == S_MUL || state_reg == S_DIV || state_reg == S_STORE) |-> sts.op == OP_START)
    `ASSERT_AT(a_resp_holds_when_busy, clk, rst_n,
        (state_reg == S_RESP && sts.out_busy) |=> state_reg == S_RESP)
    `ASSERT_AT(a_ready_after_beat, clk, rst_n, cmd.out_load |=> in_ready)

endmodule

`default_nettype wire

[src/ttp_dp.sv]
`default_nettype none
`include "assert_macros.svh"

module ttp_dp
    import ttp_pkg::*;
#(
    parameter int TIMER_COUNT = 32
)
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire ttp_in_t           in_data,
    input  wire logic              cfg_valid,
    output logic                   cfg_ready,
    input  wire logic [RATE_W-1:0] cfg_data,
    output logic                   out_valid,
    input  wire logic              out_ready,
    output ttp_out_t               out_data,
    input  wire ttp_cmd_t          cmd,
    output ttp_sts_t               sts
);

    localparam int SLOT_W = (TIMER_COUNT > 1) ? $clog2(TIMER_COUNT) : 1;

    logic [2:0]             op_reg;
    logic [7:0]             handle_reg;
    logic [31:0]            ms_reg;
    logic [TIMER_COUNT-1:0] in_use_reg;
    logic [TIMER_COUNT-1:0] running_reg;
    logic [31:0]            tick_now_reg;
    logic [RATE_W-1:0]      rate_reg;
    logic [SLOT_W-1:0]      scan_reg;
    logic [CNT_W-1:0]       cnt_reg;
    logic [ACC_W-1:0]       acc_reg;
    logic [REM_W-1:0]       rem_reg;
    logic [2:0]             res_status_reg;
    logic [7:0]             res_grant_reg;
    ttp_out_t               out_data_reg;
    logic                   out_valid_reg;
    logic [31:0]            exp_mem [TIMER_COUNT];
    logic [31:0]            exp_rd_reg;

    logic [SLOT_W-1:0]      idx;
    logic                   handle_ok;
    logic [ACC_W-1:0]       mul_next;
    logic [ACC_W-1:0]       div_acc;
    logic [REM_W-1:0]       div_rem;
    logic [REM_W:0]         trial;
    logic [31:0]            quo;
    logic [31:0]            ticks;
    logic [31:0]            expiry_new;
    logic [31:0]            age;

    assign idx       = handle_reg[SLOT_W-1:0];
    assign handle_ok = ({1'b0, handle_reg} < 9'(TIMER_COUNT));
    assign cfg_ready = 1'b1;

    // one bit of the rate per step, MSB first
    assign mul_next = {acc_reg[ACC_W-2:0], 1'b0}
                    + (rate_reg[cnt_reg] ? ACC_W'(ms_reg) : '0);

    always_comb
    begin
        div_acc = acc_reg;
        div_rem = rem_reg;
        trial   = '0;
        for (int k = 0; k < DIV_BITS; k++)
        begin
            trial   = {div_rem, div_acc[ACC_W-1]};
            div_acc = {div_acc[ACC_W-2:0], 1'b0};
            if (trial >= {1'b0, DIVISOR})
            begin
                div_rem    = REM_W'(trial - {1'b0, DIVISOR});
                div_acc[0] = 1'b1;
            end
            else
            begin
                div_rem = trial[REM_W-1:0];
            end
        end
    end

    // nonzero duration gets at least one tick
    assign quo        = acc_reg[31:0];
    assign ticks      = (ms_reg != 32'd0 && quo == 32'd0) ? 32'd1 : quo;
    assign expiry_new = tick_now_reg + ticks;
    // wrap-safe: expired when now - expiry lands in the lower half range
    assign age        = tick_now_reg - exp_rd_reg;

    always_comb
    begin
        sts           = '0;
        sts.op        = op_reg;
        sts.handle_ok = handle_ok;
        sts.in_use    = in_use_reg[idx];
        sts.running   = running_reg[idx];
        sts.scan_free = !in_use_reg[scan_reg];
        sts.scan_last = (scan_reg == SLOT_W'(TIMER_COUNT - 1));
        sts.cnt_zero  = (cnt_reg == '0);
        sts.expired   = !age[31];
        sts.out_busy  = out_valid_reg && !out_ready;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            op_reg     <= in_data.opcode;
            handle_reg <= in_data.slot_handle;
            ms_reg     <= in_data.duration_ms;
        end
        if (cmd.scan_init)
        begin
            scan_reg <= '0;
        end
        else if (cmd.scan_step)
        begin
            scan_reg <= scan_reg + 1'b1;
        end
        if (cmd.mul_init)
        begin
            acc_reg <= '0;
        end
        else if (cmd.mul_step)
        begin
            acc_reg <= mul_next;
            rem_reg <= '0;
        end
        else if (cmd.div_step)
        begin
            acc_reg <= div_acc;
            rem_reg <= div_rem;
        end
        if (cmd.res_set)
        begin
            res_status_reg <= cmd.res_status;
            res_grant_reg  <= cmd.res_grant ? 8'(scan_reg) : 8'd0;
        end
        if (cmd.out_load)
        begin
            out_data_reg.status       <= res_status_reg;
            out_data_reg.granted_slot <= res_grant_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_use_reg    <= '0;
            running_reg   <= '0;
            tick_now_reg  <= '0;
            rate_reg      <= RATE_RESET;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_valid)
            begin
                rate_reg <= cfg_data;
            end
            if (cmd.tick)
            begin
                tick_now_reg <= tick_now_reg + 32'd1;
            end
            if (cmd.claim)
            begin
                in_use_reg[scan_reg]  <= 1'b1;
                running_reg[scan_reg] <= 1'b0;
            end
            if (cmd.close)
            begin
                in_use_reg[idx]  <= 1'b0;
                running_reg[idx] <= 1'b0;
            end
            if (cmd.stop)
            begin
                running_reg[idx] <= 1'b0;
            end
            if (cmd.store)
            begin
                running_reg[idx] <= 1'b1;
            end
            if (cmd.mul_init)
            begin
                cnt_reg <= CNT_W'(MUL_STEPS - 1);
            end
            else if (cmd.mul_step)
            begin
                // last multiply step arms the divide count
                cnt_reg <= (cnt_reg == '0) ? CNT_W'(DIV_STEPS - 1) : cnt_reg - 1'b1;
            end
            else if (cmd.div_step)
            begin
                cnt_reg <= cnt_reg - 1'b1;
            end
            if (cmd.out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // expiry store; the read register samples every cycle, but a query only uses it for a running slot
    always_ff @(posedge clk)
    begin
        if (cmd.store)
        begin
            exp_mem[idx] <= expiry_new;
        end
        exp_rd_reg <= exp_mem[idx];
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    `ASSERT_AT(a_claim_free_slot, clk, rst_n, cmd.claim |-> !in_use_reg[scan_reg])
    `ASSERT_AT(a_store_open_slot, clk, rst_n, cmd.store |-> handle_ok && in_use_reg[idx])
    `ASSERT_NEVER(a_running_needs_open, clk, rst_n, (running_reg & ~in_use_reg) != '0)

endmodule

`default_nettype wire

[src/timeout_timer_pool.sv]
//  channel | dir | handshake             | beat payload
//  --------+-----+-----------------------+-------------------------------------
//  in      | in  | in_valid / in_ready   | ttp_in_t  opcode, slot_handle, duration_ms
//  out     | out | out_valid / out_ready | ttp_out_t status, granted_slot
//  cfg     | in  | cfg_valid / cfg_ready | tick_rate_hz, 17 bits (always ready)
//
//  One item at a time; one result beat per input beat, from a registered output.
//  Close, stop, tick and bad handles go from decode straight to the response state;
//  a query of a running slot passes through a query state first. Open scans one
//  slot per cycle from slot 0. Start runs a 17-step shift-add multiply and a
//  13-step divide by 1000 (4 quotient bits per step).
//  Reset clears flags, tick count and output valid and sets the rate to 1000; no clearing pass.
//  A stalled result holds the block in its response state; input stays not ready.
`default_nettype none

module timeout_timer_pool
    import ttp_pkg::*;
#(
    parameter int TIMER_COUNT = 32
)
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    output logic                   in_ready,
    input  wire ttp_in_t           in_data,
    output logic                   out_valid,
    input  wire logic              out_ready,
    output ttp_out_t               out_data,
    input  wire logic              cfg_valid,
    output logic                   cfg_ready,
    input  wire logic [RATE_W-1:0] cfg_data
);

    ttp_cmd_t cmd;
    ttp_sts_t sts;

    ttp_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .sts      (sts),
        .cmd      (cmd)
    );

    ttp_dp #(
        .TIMER_COUNT (TIMER_COUNT)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_data   (in_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .cmd       (cmd),
        .sts       (sts)
    );

endmodule

`default_nettype wire
